// File: rtl/assert_macros.svh
// Assertion macros for the bound assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/mtr_pkg.sv
`timescale 1ns / 1ps
package mtr_pkg;

	localparam int CHANNELS              = 16;
	localparam int NOTES_PER_CHANNEL     = 128;
	localparam int MAX_RELEASES_PER_ITEM = 64;
	localparam int CONTROLLERS           = 128;

	localparam int SLOTS     = CHANNELS * NOTES_PER_CHANNEL;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SCAN_W    = SLOT_W + 1;
	localparam int CTL_SLOTS = CHANNELS * CONTROLLERS;
	localparam int CTL_W     = $clog2(CTL_SLOTS);
	localparam int CNT_W     = $clog2(MAX_RELEASES_PER_ITEM + 1);

	localparam logic [7:0] GUARD_RESET = 8'd10;
	localparam logic [6:0] FULL_VELOCITY = 7'd127;
	localparam logic [7:0] LSB_OFFSET = 8'd32;

	localparam logic [2:0] OP_NOTE_ON  = 3'd0;
	localparam logic [2:0] OP_NOTE_OFF = 3'd1;
	localparam logic [2:0] OP_ALL_OFF  = 3'd2;
	localparam logic [2:0] OP_CONTROL  = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [1:0] KIND_CONTROL  = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  channel;
		logic [6:0]  number;
		logic [13:0] value;
		logic [15:0] release_delay;
		logic        hires;
		logic [31:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] message_kind;
		logic [3:0] out_channel;
		logic [7:0] out_number;
		logic [6:0] out_value;
		logic       last_of_run;
		logic       more_pending;
	} out_beat_t;

	typedef struct packed {
		logic        playing;
		logic [31:0] start;
		logic [31:0] release_at;
	} note_ent_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		note_ent_t         data;
	} note_wr_t;

	typedef struct packed {
		logic             we;
		logic [CTL_W-1:0] addr;
		logic [13:0]      data;
	} ctl_wr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NOTE,
		ST_CTL,
		ST_CTL_LSB,
		ST_SCAN
	} state_t;

	function automatic logic [SLOT_W-1:0] note_idx(logic [3:0] ch, logic [6:0] num);
		return SLOT_W'(int'(ch) * NOTES_PER_CHANNEL + int'(num));
	endfunction

	function automatic logic [CTL_W-1:0] ctl_idx(logic [3:0] ch, logic [6:0] num);
		return CTL_W'(int'(ch) * CONTROLLERS + int'(num));
	endfunction

endpackage

// File: rtl/mtr_ram.sv
`timescale 1ns / 1ps
module mtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mtr_ctrl.sv
`timescale 1ns / 1ps
module mtr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  mtr_pkg::in_beat_t          item,
	output logic                       busy,
	input  logic [7:0]                 guard,
	output logic [mtr_pkg::SLOT_W-1:0] note_raddr,
	input  mtr_pkg::note_ent_t         note_rdata,
	output mtr_pkg::note_wr_t          note_wr,
	output logic [mtr_pkg::CTL_W-1:0]  ctl_raddr,
	input  logic [13:0]                ctl_rdata,
	output mtr_pkg::ctl_wr_t           ctl_wr,
	output logic                       result_valid,
	output mtr_pkg::out_beat_t         result
);

	mtr_pkg::state_t state_q, state_d;
	mtr_pkg::in_beat_t item_q, item_d;
	logic [mtr_pkg::CTL_W-1:0] clr_q, clr_d;
	logic [mtr_pkg::SCAN_W-1:0] addr_q, addr_d, end_q, end_d;
	logic [mtr_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic timed_q, timed_d;
	logic rd_vld_s1, rd_vld_d;
	logic [mtr_pkg::SLOT_W-1:0] idx_s1, idx_d;
	mtr_pkg::out_beat_t pend_q, pend_d;
	logic pend_vld_q, pend_vld_d;
	logic res_vld_q, emit;
	mtr_pkg::out_beat_t res_q, res_d;
	logic issuing, cand;
	logic [31:0] age, since;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mtr_pkg::ST_CLEAR;
			clr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
			cnt_q      <= '0;
			addr_q     <= '0;
			end_q      <= '0;
			timed_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			rd_vld_s1  <= rd_vld_d;
			pend_vld_q <= pend_vld_d;
			res_vld_q  <= emit;
			cnt_q      <= cnt_d;
			addr_q     <= addr_d;
			end_q      <= end_d;
			timed_q    <= timed_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		idx_s1 <= idx_d;
		pend_q <= pend_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d    = state_q;
		item_d     = item_q;
		clr_d      = clr_q;
		addr_d     = addr_q;
		end_d      = end_q;
		cnt_d      = cnt_q;
		timed_d    = timed_q;
		rd_vld_d   = 1'b0;
		idx_d      = idx_s1;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		emit       = 1'b0;
		res_d      = pend_q;
		note_raddr = addr_q[mtr_pkg::SLOT_W-1:0];
		ctl_raddr  = mtr_pkg::ctl_idx(item.channel, item.number);
		note_wr    = '0;
		ctl_wr     = '0;
		age        = item_q.now_ms - note_rdata.start;
		since      = item_q.now_ms - note_rdata.release_at;
		issuing    = addr_q < end_q;
		cand       = note_rdata.playing && (!timed_q || ((note_rdata.release_at != '0)
			&& (since != '0) && !since[31]));

		case (state_q)
			mtr_pkg::ST_CLEAR: begin
				note_wr.we   = int'(clr_q) < mtr_pkg::SLOTS;
				note_wr.addr = clr_q[mtr_pkg::SLOT_W-1:0];
				ctl_wr.we    = 1'b1;
				ctl_wr.addr  = clr_q;
				if (clr_q == mtr_pkg::CTL_W'(mtr_pkg::CTL_SLOTS - 1)) begin
					state_d = mtr_pkg::ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			mtr_pkg::ST_IDLE: begin
				note_raddr = mtr_pkg::note_idx(item.channel, item.number);
				if (start && int'(item.channel) < mtr_pkg::CHANNELS) begin
					item_d = item;
					case (item.operation)
						mtr_pkg::OP_NOTE_ON, mtr_pkg::OP_NOTE_OFF: begin
							if (int'(item.number) < mtr_pkg::NOTES_PER_CHANNEL) begin
								state_d = mtr_pkg::ST_NOTE;
							end
						end
						mtr_pkg::OP_CONTROL: begin
							state_d = mtr_pkg::ST_CTL;
						end
						mtr_pkg::OP_ALL_OFF: begin
							addr_d     = mtr_pkg::SCAN_W'(int'(item.channel)
								* mtr_pkg::NOTES_PER_CHANNEL);
							end_d      = mtr_pkg::SCAN_W'((int'(item.channel) + 1)
								* mtr_pkg::NOTES_PER_CHANNEL);
							timed_d    = 1'b0;
							cnt_d      = '0;
							pend_vld_d = 1'b0;
							state_d    = mtr_pkg::ST_SCAN;
						end
						mtr_pkg::OP_TICK: begin
							addr_d     = '0;
							end_d      = mtr_pkg::SCAN_W'(mtr_pkg::SLOTS);
							timed_d    = 1'b1;
							cnt_d      = '0;
							pend_vld_d = 1'b0;
							state_d    = mtr_pkg::ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			mtr_pkg::ST_NOTE: begin
				state_d                = mtr_pkg::ST_IDLE;
				note_wr.addr           = mtr_pkg::note_idx(item_q.channel, item_q.number);
				res_d.out_channel      = item_q.channel;
				res_d.out_number       = {1'b0, item_q.number};
				res_d.out_value        = item_q.value[6:0];
				res_d.last_of_run      = 1'b1;
				res_d.more_pending     = 1'b0;
				if (item_q.operation == mtr_pkg::OP_NOTE_ON) begin
					res_d.message_kind = mtr_pkg::KIND_NOTE_ON;
					note_wr.data.playing = 1'b1;
					note_wr.data.start = item_q.now_ms;
					note_wr.data.release_at = (item_q.release_delay != '0)
						? item_q.now_ms + 32'(item_q.release_delay) : '0;
					if (!(note_rdata.playing && age < {24'd0, guard})) begin
						note_wr.we = 1'b1;
						emit       = 1'b1;
					end
				end else begin
					res_d.message_kind = mtr_pkg::KIND_NOTE_OFF;
					note_wr.data         = note_rdata;
					note_wr.data.playing = 1'b0;
					if (note_rdata.playing) begin
						note_wr.we = 1'b1;
						emit       = 1'b1;
					end
				end
			end
			mtr_pkg::ST_CTL: begin
				state_d            = mtr_pkg::ST_IDLE;
				ctl_wr.addr        = mtr_pkg::ctl_idx(item_q.channel, item_q.number);
				ctl_wr.data        = item_q.value;
				res_d.message_kind = mtr_pkg::KIND_CONTROL;
				res_d.out_channel  = item_q.channel;
				res_d.out_number   = {1'b0, item_q.number};
				res_d.out_value    = item_q.hires ? item_q.value[13:7] : item_q.value[6:0];
				res_d.last_of_run  = !item_q.hires;
				res_d.more_pending = 1'b0;
				if (ctl_rdata != item_q.value) begin
					ctl_wr.we = 1'b1;
					emit      = 1'b1;
					if (item_q.hires) begin
						state_d = mtr_pkg::ST_CTL_LSB;
					end
				end
			end
			mtr_pkg::ST_CTL_LSB: begin
				state_d            = mtr_pkg::ST_IDLE;
				emit               = 1'b1;
				res_d.message_kind = mtr_pkg::KIND_CONTROL;
				res_d.out_channel  = item_q.channel;
				res_d.out_number   = {1'b0, item_q.number} + mtr_pkg::LSB_OFFSET;
				res_d.out_value    = item_q.value[6:0];
				res_d.last_of_run  = 1'b1;
				res_d.more_pending = 1'b0;
			end
			mtr_pkg::ST_SCAN: begin
				if (issuing) begin
					addr_d   = addr_q + 1'b1;
					rd_vld_d = 1'b1;
					idx_d    = addr_q[mtr_pkg::SLOT_W-1:0];
				end
				if (rd_vld_s1 && cand) begin
					if (cnt_q == mtr_pkg::CNT_W'(mtr_pkg::MAX_RELEASES_PER_ITEM)) begin
						emit               = 1'b1;
						res_d.last_of_run  = 1'b1;
						res_d.more_pending = 1'b1;
						rd_vld_d           = 1'b0;
						state_d            = mtr_pkg::ST_IDLE;
					end else begin
						note_wr.we           = 1'b1;
						note_wr.addr         = idx_s1;
						note_wr.data         = note_rdata;
						note_wr.data.playing = 1'b0;
						emit                 = pend_vld_q;
						pend_d.message_kind  = mtr_pkg::KIND_NOTE_OFF;
						pend_d.out_channel   = 4'(int'(idx_s1) / mtr_pkg::NOTES_PER_CHANNEL);
						pend_d.out_number    = 8'(int'(idx_s1) % mtr_pkg::NOTES_PER_CHANNEL);
						pend_d.out_value     = mtr_pkg::FULL_VELOCITY;
						pend_d.last_of_run   = 1'b0;
						pend_d.more_pending  = 1'b0;
						pend_vld_d           = 1'b1;
						cnt_d                = cnt_q + 1'b1;
					end
				end else if (!rd_vld_s1 && !issuing) begin
					emit               = pend_vld_q;
					res_d.last_of_run  = 1'b1;
					res_d.more_pending = 1'b0;
					state_d            = mtr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtr_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = state_q != mtr_pkg::ST_IDLE;
	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// File: rtl/midi_note_tracker_with_sustain_top.sv
`timescale 1ns / 1ps
// MIDI note tracker with sustain.
// Input: an item is taken at a rising edge where start is high and busy is low.
// Configuration: cfg_we writes cfg_data into the retrigger guard (milliseconds)
// at any edge; it should only change while the block is idle.
// Output: each result beat is shown on result for one cycle with result_valid
// high; the receiver cannot stall, so beats are never held back.
// Sequencing: a note or control item holds busy while in ST_NOTE or ST_CTL; its
// beat is shown in the cycle after that, when busy is already low, so the next
// item can be taken at the edge that ends the beat's cycle. A hires control also
// passes through ST_CTL_LSB and shows the LSB beat in the cycle after the MSB beat.
// A dropped note or unchanged control holds busy the same way without a beat; an
// unknown operation leaves the block idle and the next item can be taken at the
// following edge. All-off and tick items scan the note table one entry per cycle
// through the read port of the note memory: busy stays high while the scan runs,
// and the run ends early when the release limit cuts it short; the final beat
// shows in the first cycle with busy low.
// Reset: the guard returns to 10 ms, and a clearing pass writes all 2048 note
// and controller entries, one per cycle, with busy held high until it ends.
module midi_note_tracker_with_sustain_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mtr_pkg::in_beat_t  item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	output logic               result_valid,
	output mtr_pkg::out_beat_t result
);

	logic [7:0] guard_q;
	logic [mtr_pkg::SLOT_W-1:0] note_raddr;
	mtr_pkg::note_ent_t note_rdata;
	mtr_pkg::note_wr_t note_wr;
	logic [mtr_pkg::CTL_W-1:0] ctl_raddr;
	logic [13:0] ctl_rdata;
	mtr_pkg::ctl_wr_t ctl_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= mtr_pkg::GUARD_RESET;
		end else if (cfg_we) begin
			guard_q <= cfg_data;
		end
	end

	mtr_ram #(
		.WIDTH($bits(mtr_pkg::note_ent_t)),
		.DEPTH(mtr_pkg::SLOTS)
	) u_note_ram (
		.clk  (clk),
		.we   (note_wr.we),
		.waddr(note_wr.addr),
		.wdata(note_wr.data),
		.raddr(note_raddr),
		.rdata(note_rdata)
	);

	mtr_ram #(
		.WIDTH(14),
		.DEPTH(mtr_pkg::CTL_SLOTS)
	) u_ctl_ram (
		.clk  (clk),
		.we   (ctl_wr.we),
		.waddr(ctl_wr.addr),
		.wdata(ctl_wr.data),
		.raddr(ctl_raddr),
		.rdata(ctl_rdata)
	);

	mtr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.guard       (guard_q),
		.note_raddr  (note_raddr),
		.note_rdata  (note_rdata),
		.note_wr     (note_wr),
		.ctl_raddr   (ctl_raddr),
		.ctl_rdata   (ctl_rdata),
		.ctl_wr      (ctl_wr),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// File: rtl/mtr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input mtr_pkg::in_beat_t  item,
	input logic               result_valid,
	input mtr_pkg::out_beat_t result
);

	logic known_op;
	logic lsb_due;

	assign known_op = item.operation == mtr_pkg::OP_NOTE_ON
		|| item.operation == mtr_pkg::OP_NOTE_OFF
		|| item.operation == mtr_pkg::OP_ALL_OFF
		|| item.operation == mtr_pkg::OP_CONTROL
		|| item.operation == mtr_pkg::OP_TICK;

	assign lsb_due = result_valid && !result.last_of_run
		&& result.message_kind == mtr_pkg::KIND_CONTROL;

	`AST_NEXT(a_known_op_busy, clk, arst_n, start && !busy && known_op, busy)
	`AST_IMPLY(a_mid_run_busy, clk, arst_n, result_valid && !result.last_of_run, busy)
	`AST_IMPLY(a_more_on_last, clk, arst_n, result_valid && result.more_pending, result.last_of_run)
	`AST_NEXT(a_lsb_follows, clk, arst_n, lsb_due, result_valid && result.last_of_run)

endmodule

bind midi_note_tracker_with_sustain_top mtr_checker u_mtr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);

// File: test/note_tracker_checker.sv
`timescale 1ns / 1ps
module note_tracker_checker
	import mtr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_beat_t  item,
	input  logic      cfg_we,
	input  logic [7:0] cfg_data,
	input  logic      result_valid,
	input  out_beat_t result,
	output int        fails,
	output int        pending,
	output int        beats_checked,
	output int        cut_runs
);

	bit          playing [SLOTS];
	logic [31:0] started_at [SLOTS];
	logic [31:0] release_at [SLOTS];
	logic [13:0] ctl_last [CTL_SLOTS];
	logic [7:0]  guard_ms;
	out_beat_t   expected_msgs [$];

	initial begin
		fails = 0;
		pending = 0;
		beats_checked = 0;
		cut_runs = 0;
	end

	function automatic bit release_due(int idx, logic [31:0] now);
		logic [31:0] age;
		age = now - release_at[idx];
		return release_at[idx] != 32'd0 && age != 32'd0 && age < 32'h8000_0000;
	endfunction

	task automatic report_mismatch(string what, out_beat_t got, out_beat_t want);
		$display("%0t mismatch in %s: got %p, expected %p", $realtime, what, got, want);
		fails++;
	endtask

	task automatic predict_messages(in_beat_t b);
		out_beat_t run [$];
		out_beat_t m;
		int idx;
		int lo;
		int hi;
		bit more;
		bit timed;
		more = 1'b0;
		m = '0;
		m.out_channel = b.channel;
		case (b.operation)
			OP_NOTE_ON: begin
				idx = int'(b.channel) * NOTES_PER_CHANNEL + int'(b.number);
				if (!(playing[idx] && (b.now_ms - started_at[idx]) < 32'(guard_ms))) begin
					m.message_kind = KIND_NOTE_ON;
					m.out_number = {1'b0, b.number};
					m.out_value = b.value[6:0];
					run = {run, m};
					playing[idx] = 1'b1;
					started_at[idx] = b.now_ms;
					release_at[idx] = (b.release_delay != 16'd0) ?
						b.now_ms + 32'(b.release_delay) : 32'd0;
				end
			end
			OP_NOTE_OFF: begin
				idx = int'(b.channel) * NOTES_PER_CHANNEL + int'(b.number);
				if (playing[idx]) begin
					m.message_kind = KIND_NOTE_OFF;
					m.out_number = {1'b0, b.number};
					m.out_value = b.value[6:0];
					run = {run, m};
					playing[idx] = 1'b0;
				end
			end
			OP_ALL_OFF, OP_TICK: begin
				timed = (b.operation == OP_TICK);
				lo = timed ? 0 : int'(b.channel);
				hi = timed ? CHANNELS : int'(b.channel) + 1;
				for (int c = lo; c < hi && !more; c++) begin
					for (int k = 0; k < NOTES_PER_CHANNEL; k++) begin
						idx = c * NOTES_PER_CHANNEL + k;
						if (!playing[idx] || (timed && !release_due(idx, b.now_ms)))
							continue;
						if (run.size() >= MAX_RELEASES_PER_ITEM) begin
							more = 1'b1;
							break;
						end
						m.message_kind = KIND_NOTE_OFF;
						m.out_channel = 4'(c);
						m.out_number = 8'(k);
						m.out_value = FULL_VELOCITY;
						run = {run, m};
						playing[idx] = 1'b0;
					end
				end
			end
			OP_CONTROL: begin
				idx = int'(b.channel) * CONTROLLERS + int'(b.number);
				if (ctl_last[idx] != b.value) begin
					m.message_kind = KIND_CONTROL;
					m.out_number = {1'b0, b.number};
					if (b.hires) begin
						m.out_value = b.value[13:7];
						run = {run, m};
						m.out_number = {1'b0, b.number} + LSB_OFFSET;
						m.out_value = b.value[6:0];
						run = {run, m};
					end else begin
						m.out_value = b.value[6:0];
						run = {run, m};
					end
					ctl_last[idx] = b.value;
				end
			end
			default: begin
			end
		endcase
		if (run.size() > 0) begin
			run[run.size() - 1].last_of_run = 1'b1;
			run[run.size() - 1].more_pending = more;
		end
		if (more)
			cut_runs++;
		expected_msgs = {expected_msgs, run};
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			foreach (playing[i])
				playing[i] = 1'b0;
			foreach (ctl_last[i])
				ctl_last[i] = '0;
			guard_ms = GUARD_RESET;
			expected_msgs.delete();
		end else begin
			if (result_valid) begin
				beats_checked++;
				if (expected_msgs.size() == 0) begin
					report_mismatch("unexpected beat", result, '0);
				end else begin
					want = expected_msgs.pop_front();
					if (result.message_kind !== want.message_kind)
						report_mismatch("message_kind", result, want);
					if (result.out_channel !== want.out_channel)
						report_mismatch("out_channel", result, want);
					if (result.out_number !== want.out_number)
						report_mismatch("out_number", result, want);
					if (result.out_value !== want.out_value)
						report_mismatch("out_value", result, want);
					if (result.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", result, want);
					if (result.more_pending !== want.more_pending)
						report_mismatch("more_pending", result, want);
				end
			end
			if (cfg_we)
				guard_ms = cfg_data;
			if (start && !busy)
				predict_messages(item);
		end
		pending = expected_msgs.size();
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import mtr_pkg::*;

	localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_beat_t  item;
	logic      cfg_we;
	logic [7:0] cfg_data;
	logic      result_valid;
	out_beat_t result;

	int fails;
	int pending;
	int beats_checked;
	int cut_runs;
	int items_sent;
	int sender_idle_pct;
	logic [31:0] clock_ms;

	midi_note_tracker_with_sustain_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	note_tracker_checker watcher (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result),
		.fails(fails),
		.pending(pending),
		.beats_checked(beats_checked),
		.cut_runs(cut_runs)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic in_beat_t make_beat(logic [2:0] op, logic [3:0] ch, logic [6:0] num,
			logic [13:0] val, logic [15:0] sus, logic hires, logic [31:0] now);
		in_beat_t b;
		b.operation = op;
		b.channel = ch;
		b.number = num;
		b.value = val;
		b.release_delay = sus;
		b.hires = hires;
		b.now_ms = now;
		return b;
	endfunction

	task automatic send_beat(in_beat_t b);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		item <= b;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (2100) @(posedge clk);
	endtask

	task automatic write_guard(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_beat();
		int pick;
		logic [2:0] op;
		logic [3:0] ch;
		logic [6:0] num;
		logic [13:0] val;
		logic [15:0] sus;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = OP_NOTE_ON;
		else if (pick < 60)
			op = OP_NOTE_OFF;
		else if (pick < 63)
			op = OP_ALL_OFF;
		else if (pick < 85)
			op = OP_CONTROL;
		else if (pick < 93)
			op = OP_TICK;
		else
			op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
		ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
		num = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: val = '0;
			1: val = 14'h3FFF;
			default: val = 14'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: sus = '0;
			3: sus = 16'($urandom);
			default: sus = 16'($urandom_range(1, 40));
		endcase
		if ($urandom_range(0, 99) < 3)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + 32'($urandom_range(0, 15));
		send_beat(make_beat(op, ch, num, val, sus, 1'($urandom), clock_ms));
	endtask

	task automatic note_burst(logic [3:0] ch, int count, bit timed);
		for (int i = 0; i < count; i++) begin
			clock_ms = clock_ms + 32'($urandom_range(0, 1));
			send_beat(make_beat(OP_NOTE_ON, ch, 7'(i), 14'($urandom),
				timed ? 16'($urandom_range(1, 3)) : 16'd0, 1'($urandom), clock_ms));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		items_sent = 0;
		sender_idle_pct = 0;
		clock_ms = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(make_beat(OP_NOTE_ON, 4'd0, 7'd0, 14'h3FFF, 16'd0, 1'b0, 32'd0));
		send_beat(make_beat(OP_NOTE_ON, 4'd0, 7'd0, 14'd1, 16'd0, 1'b0, 32'd5));
		send_beat(make_beat(OP_NOTE_ON, 4'd0, 7'd0, 14'd2, 16'd0, 1'b0, 32'd10));
		send_beat(make_beat(OP_NOTE_OFF, 4'd0, 7'd0, 14'h3FFF, 16'd0, 1'b0, 32'd11));
		send_beat(make_beat(OP_NOTE_OFF, 4'd0, 7'd0, 14'd3, 16'd0, 1'b0, 32'd12));
		send_beat(make_beat(OP_NOTE_ON, 4'd15, 7'd127, 14'd0, 16'hFFFF, 1'b1,
			32'hFFFF_FFFF));
		send_beat(make_beat(OP_NOTE_ON, 4'd1, 7'd5, 14'd64, 16'd16, 1'b0, 32'hFFFF_FFF0));
		send_beat(make_beat(OP_TICK, 4'd0, 7'd0, 14'd0, 16'd0, 1'b0, 32'd100));
		send_beat(make_beat(OP_TICK, 4'd9, 7'd0, 14'd0, 16'd0, 1'b0, 32'd70000));
		send_beat(make_beat(OP_CONTROL, 4'd2, 7'd0, 14'd0, 16'd0, 1'b0, 32'd70001));
		send_beat(make_beat(OP_CONTROL, 4'd2, 7'd0, 14'h3FFF, 16'd0, 1'b1, 32'd70002));
		send_beat(make_beat(OP_CONTROL, 4'd2, 7'd127, 14'd200, 16'd0, 1'b0, 32'd70003));
		send_beat(make_beat(OP_CONTROL, 4'd2, 7'd127, 14'd5000, 16'd0, 1'b1, 32'd70004));
		send_beat(make_beat(OP_CONTROL, 4'd2, 7'd127, 14'd5000, 16'd0, 1'b0, 32'd70005));
		send_beat(make_beat(OP_ALL_OFF, 4'd1, 7'd0, 14'd0, 16'd0, 1'b0, 32'd70006));
		send_beat(make_beat(OP_ALL_OFF, 4'd1, 7'd0, 14'd0, 16'd0, 1'b0, 32'd70007));
		for (int op = int'(OP_RESERVED_FIRST); op <= int'(OP_RESERVED_LAST); op++)
			send_beat(make_beat(3'(op), 4'd0, 7'd1, 14'd9, 16'd0, 1'b0, 32'd70008));
		send_beat(make_beat(OP_NOTE_ON, 4'd3, 7'd9, 14'd50, 16'd0, 1'b0, 32'hFFFF_FFFE));
		send_beat(make_beat(OP_NOTE_ON, 4'd3, 7'd9, 14'd51, 16'd0, 1'b0, 32'd3));
		send_beat(make_beat(OP_TICK, 4'd0, 7'd0, 14'd0, 16'd0, 1'b0, 32'h8000_0000));
		clock_ms = 32'd80000;

		settle();
		write_guard(8'd255);
		sender_idle_pct = 37;
		for (int i = 0; i < 30; i++)
			random_beat();

		settle();
		write_guard(8'd0);
		sender_idle_pct = 79;
		note_burst(4'd6, 66, 1'b0);
		send_beat(make_beat(OP_ALL_OFF, 4'd6, 7'd0, 14'd0, 16'd0, 1'b0, clock_ms));
		send_beat(make_beat(OP_ALL_OFF, 4'd6, 7'd0, 14'd0, 16'd0, 1'b0, clock_ms));

		settle();
		write_guard(8'($urandom_range(1, 254)));
		sender_idle_pct = 0;
		note_burst(4'd11, 70, 1'b1);
		clock_ms = clock_ms + 32'd10;
		send_beat(make_beat(OP_TICK, 4'd0, 7'd0, 14'd0, 16'd0, 1'b0, clock_ms));
		send_beat(make_beat(OP_TICK, 4'd0, 7'd0, 14'd0, 16'd0, 1'b0, clock_ms));
		for (int i = 0; i < 20; i++)
			random_beat();

		settle();
		$display("covered %0d items over four guard settings, %0d result beats checked,",
			items_sent, beats_checked);
		$display("%0d release runs cut at the per-item limit", cut_runs);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: midi_note_tracker_with_sustain_top.f
+incdir+rtl
rtl/mtr_pkg.sv
rtl/mtr_ram.sv
rtl/mtr_ctrl.sv
rtl/midi_note_tracker_with_sustain_top.sv
rtl/mtr_checker.sv
test/note_tracker_checker.sv
test/testbench.sv
